[hdl/scm_pkg.sv]
`timescale 1ns / 1ps
// Package for the stereo correlation meter: state and selector types,
// register codes, reset values and fixed widths. Depends on nothing.
package scm_pkg;

	localparam int SUM_W      = 64;
	localparam int DECAY_W    = 24;
	localparam int MIN_DEN_W  = 40;
	localparam int CORR_W     = 16;
	localparam int CORR_FRAC  = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;
	localparam int MUL_W      = 33;
	localparam int ROOT_W     = 63;
	localparam int CNT_W      = 6;
	localparam int PP_STEPS   = 4;
	localparam int SQRT_STEPS = 63;

	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEN = 2'd1;

	localparam logic [DECAY_W-1:0]   DECAY_RESET   = 24'd16775538;
	localparam logic [MIN_DEN_W-1:0] MIN_DEN_RESET = 40'd70368744;
	localparam logic [CORR_FRAC:0]   CORR_ONE      = 15'd16384;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_MAG,
		ST_LO,
		ST_HI,
		ST_PP,
		ST_SQRT,
		ST_CMP,
		ST_CLAMP,
		ST_DIV,
		ST_SIGN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SUM_CROSS,
		SUM_LEFT,
		SUM_RIGHT
	} sum_sel_t;

endpackage

[hdl/scm_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the stereo correlation meter: sample input, result
// output and configuration write. Depends on scm_pkg for widths.
interface scm_sample_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic                          block_end;
	modport source(output valid, left_sample, right_sample, block_end, input ready);
	modport sink(input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface scm_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [scm_pkg::CORR_W-1:0] correlation;
	logic                              silent;
	modport source(output valid, correlation, silent, input ready);
	modport sink(input valid, correlation, silent, output ready);
endinterface

interface scm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [scm_pkg::CFG_IDX_W-1:0]   index;
	logic [scm_pkg::CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/stereo_correlation_meter.sv]
`timescale 1ns / 1ps
// Top level of the stereo correlation meter: leaky sums, square root and
// divide on one shared multiplier. Depends on scm_pkg and scm_if.
//
// Each sample beat updates three leaky sums (left times right, left squared,
// right squared) one after another on a single 33 by 33 bit multiplier, each
// through the steps product and saturating add, magnitude, and the two partial
// products of the decay multiply. A beat with block_end set goes on to form
// the 126-bit product of the energies from four partial products on the
// multiplier, takes its square root one result bit a cycle, and then divides
// the cross sum by it one quotient bit a cycle, skipped when the ratio clamps
// or the block is silent. The sample channel is not ready while an item is in
// work; a finished result sits in an output register so the next sample can
// be accepted while it waits to be taken. Configuration writes are always
// accepted and should only be issued while the block is idle.
module stereo_correlation_meter #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	scm_sample_if.sink     samples,
	scm_result_if.source   result,
	scm_cfg_if.sink        cfg
);

	localparam int EXT_W = scm_pkg::MUL_W - SAMPLE_BITS;

	// Saturating add at the signed 64-bit limits.
	function automatic logic signed [scm_pkg::SUM_W-1:0] sat_add(
		input logic signed [scm_pkg::SUM_W-1:0] a,
		input logic signed [scm_pkg::SUM_W-1:0] b
	);
		logic [scm_pkg::SUM_W:0] s;
		s = {a[scm_pkg::SUM_W-1], a} + {b[scm_pkg::SUM_W-1], b};
		if (s[scm_pkg::SUM_W] != s[scm_pkg::SUM_W-1])
			return s[scm_pkg::SUM_W] ? {1'b1, {(scm_pkg::SUM_W-1){1'b0}}}
			                         : {1'b0, {(scm_pkg::SUM_W-1){1'b1}}};
		return s[scm_pkg::SUM_W-1:0];
	endfunction

	// Configuration registers.
	logic [scm_pkg::DECAY_W-1:0]   decay_q;
	logic [scm_pkg::MIN_DEN_W-1:0] min_den_q;

	// Leaky sums.
	logic signed [scm_pkg::SUM_W-1:0] cross_q, left_q, right_q;

	// Sequencer and working registers.
	scm_pkg::state_t   state_q, state_d;
	scm_pkg::sum_sel_t sel_q;
	logic [scm_pkg::CNT_W-1:0] cnt_q;
	logic signed [SAMPLE_BITS-1:0] l_q, r_q;
	logic end_q;
	logic signed [scm_pkg::SUM_W-1:0] acc_q;
	logic neg_q;
	logic [scm_pkg::SUM_W-1:0] mag_q;
	logic [55:0] lowp_q;
	logic [2*scm_pkg::SUM_W-1:0] prod_q;
	logic [scm_pkg::SUM_W:0] rem_q;
	logic [scm_pkg::ROOT_W-1:0] root_q;
	logic [scm_pkg::SUM_W:0] num_q;
	logic [scm_pkg::CORR_FRAC:0] quo_q;
	logic signed [scm_pkg::CORR_W-1:0] res_corr_q;
	logic res_silent_q;

	// Output register.
	logic out_valid_q;
	logic signed [scm_pkg::CORR_W-1:0] corr_q;
	logic silent_q;

	// Shared multiplier.
	logic signed [scm_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*scm_pkg::MUL_W-1:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic in_ready;
	logic signed [scm_pkg::SUM_W-1:0] cur_sum;
	logic signed [scm_pkg::MUL_W-1:0] l_ext, r_ext;

	assign l_ext = {{EXT_W{l_q[SAMPLE_BITS-1]}}, l_q};
	assign r_ext = {{EXT_W{r_q[SAMPLE_BITS-1]}}, r_q};

	always_comb begin
		case (sel_q)
			scm_pkg::SUM_CROSS: cur_sum = cross_q;
			scm_pkg::SUM_LEFT:  cur_sum = left_q;
			scm_pkg::SUM_RIGHT: cur_sum = right_q;
			default:            cur_sum = cross_q;
		endcase
	end

	// Decay combine: (high partial << 8) + (low partial >> 24), rounded toward
	// minus infinity for a negative sum.
	logic [scm_pkg::SUM_W-1:0] decay_q_sum;
	logic signed [scm_pkg::SUM_W-1:0] decayed;
	assign decay_q_sum = {mul_p[55:0], 8'b0} + {32'b0, lowp_q[55:24]}
	                   + {63'b0, (neg_q && (lowp_q[23:0] != 24'd0))};
	assign decayed = neg_q ? -$signed(decay_q_sum) : $signed(decay_q_sum);

	// Square root step: bring down two bits of the product.
	logic [scm_pkg::SUM_W+2:0] sq_rem, sq_trial;
	logic sq_ge;
	assign sq_rem   = {rem_q, prod_q[125:124]};
	assign sq_trial = {2'b0, root_q, 2'b01};
	assign sq_ge    = sq_rem >= sq_trial;

	logic [scm_pkg::SUM_W:0] den_ext, div_num;
	logic den_silent, clamp_ge, div_ge, out_free;
	assign den_ext    = {2'b0, root_q};
	assign den_silent = root_q <= {23'b0, min_den_q};
	assign clamp_ge   = num_q >= den_ext;
	assign div_num    = {num_q[scm_pkg::SUM_W-1:0], 1'b0};
	assign div_ge     = div_num >= den_ext;
	assign out_free   = !out_valid_q || result.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			scm_pkg::ST_IDLE: if (samples.valid) state_d = scm_pkg::ST_PROD;
			scm_pkg::ST_PROD: state_d = scm_pkg::ST_MAG;
			scm_pkg::ST_MAG:  state_d = scm_pkg::ST_LO;
			scm_pkg::ST_LO:   state_d = scm_pkg::ST_HI;
			scm_pkg::ST_HI: begin
				if (sel_q != scm_pkg::SUM_RIGHT)
					state_d = scm_pkg::ST_PROD;
				else if (end_q)
					state_d = scm_pkg::ST_PP;
				else
					state_d = scm_pkg::ST_IDLE;
			end
			scm_pkg::ST_PP:
				if (cnt_q == scm_pkg::CNT_W'(scm_pkg::PP_STEPS - 1)) state_d = scm_pkg::ST_SQRT;
			scm_pkg::ST_SQRT:
				if (cnt_q == scm_pkg::CNT_W'(scm_pkg::SQRT_STEPS - 1)) state_d = scm_pkg::ST_CMP;
			scm_pkg::ST_CMP:
				state_d = den_silent ? scm_pkg::ST_OUT : scm_pkg::ST_CLAMP;
			scm_pkg::ST_CLAMP:
				state_d = clamp_ge ? scm_pkg::ST_SIGN : scm_pkg::ST_DIV;
			scm_pkg::ST_DIV:
				if (cnt_q == scm_pkg::CNT_W'(scm_pkg::CORR_FRAC - 1)) state_d = scm_pkg::ST_SIGN;
			scm_pkg::ST_SIGN: state_d = scm_pkg::ST_OUT;
			scm_pkg::ST_OUT:  if (out_free) state_d = scm_pkg::ST_IDLE;
			default:          state_d = scm_pkg::ST_IDLE;
		endcase
	end

	// Control outputs: handshake and multiplier operand selection.
	always_comb begin
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			scm_pkg::ST_IDLE: in_ready = 1'b1;
			scm_pkg::ST_PROD: begin
				case (sel_q)
					scm_pkg::SUM_CROSS: begin mul_a = l_ext; mul_b = r_ext; end
					scm_pkg::SUM_LEFT:  begin mul_a = l_ext; mul_b = l_ext; end
					scm_pkg::SUM_RIGHT: begin mul_a = r_ext; mul_b = r_ext; end
					default:            begin mul_a = l_ext; mul_b = r_ext; end
				endcase
			end
			scm_pkg::ST_LO: begin
				mul_a = {1'b0, mag_q[31:0]};
				mul_b = {9'b0, decay_q};
			end
			scm_pkg::ST_HI: begin
				mul_a = {1'b0, mag_q[63:32]};
				mul_b = {9'b0, decay_q};
			end
			scm_pkg::ST_PP: begin
				// Energy sums are never negative, so bit 63 is always clear.
				mul_a = cnt_q[1] ? {2'b0, left_q[62:32]}  : {1'b0, left_q[31:0]};
				mul_b = cnt_q[0] ? {2'b0, right_q[62:32]} : {1'b0, right_q[31:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign samples.ready = in_ready;
	assign cfg.ready     = 1'b1;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q   <= scm_pkg::DECAY_RESET;
			min_den_q <= scm_pkg::MIN_DEN_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == scm_pkg::CFG_DECAY)
				decay_q <= cfg.data[scm_pkg::DECAY_W-1:0];
			else if (cfg.index == scm_pkg::CFG_MIN_DEN)
				min_den_q <= cfg.data[scm_pkg::MIN_DEN_W-1:0];
		end
	end

	// Control state and leaky sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scm_pkg::ST_IDLE;
			sel_q   <= scm_pkg::SUM_CROSS;
			cnt_q   <= '0;
			cross_q <= '0;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				scm_pkg::ST_IDLE: sel_q <= scm_pkg::SUM_CROSS;
				scm_pkg::ST_HI: begin
					case (sel_q)
						scm_pkg::SUM_CROSS: begin
							cross_q <= decayed;
							sel_q   <= scm_pkg::SUM_LEFT;
						end
						scm_pkg::SUM_LEFT: begin
							left_q <= decayed;
							sel_q  <= scm_pkg::SUM_RIGHT;
						end
						default: right_q <= decayed;
					endcase
					cnt_q <= '0;
				end
				scm_pkg::ST_PP, scm_pkg::ST_SQRT, scm_pkg::ST_DIV:
					cnt_q <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
				scm_pkg::ST_CLAMP: cnt_q <= '0;
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			scm_pkg::ST_IDLE: begin
				l_q   <= samples.left_sample;
				r_q   <= samples.right_sample;
				end_q <= samples.block_end;
			end
			scm_pkg::ST_PROD: acc_q <= sat_add(cur_sum, mul_p[scm_pkg::SUM_W-1:0]);
			scm_pkg::ST_MAG: begin
				neg_q <= acc_q[scm_pkg::SUM_W-1];
				mag_q <= acc_q[scm_pkg::SUM_W-1] ? -acc_q : acc_q;
			end
			scm_pkg::ST_LO: lowp_q <= mul_p[55:0];
			scm_pkg::ST_HI: begin
				prod_q <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			scm_pkg::ST_PP: begin
				case (cnt_q[1:0])
					2'd0:    prod_q <= prod_q + {64'b0, mul_p[63:0]};
					2'd3:    prod_q <= prod_q + {mul_p[63:0], 64'b0};
					default: prod_q <= prod_q + {32'b0, mul_p[63:0], 32'b0};
				endcase
			end
			scm_pkg::ST_SQRT: begin
				prod_q <= {prod_q[125:0], 2'b00};
				if (sq_ge) begin
					rem_q  <= (scm_pkg::SUM_W+1)'(sq_rem - sq_trial);
					root_q <= {root_q[scm_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= sq_rem[scm_pkg::SUM_W:0];
					root_q <= {root_q[scm_pkg::ROOT_W-2:0], 1'b0};
				end
			end
			scm_pkg::ST_CMP: begin
				num_q        <= {1'b0, cross_q[scm_pkg::SUM_W-1] ? -cross_q : cross_q};
				res_corr_q   <= '0;
				res_silent_q <= den_silent;
				quo_q        <= '0;
			end
			scm_pkg::ST_CLAMP: if (clamp_ge) quo_q <= scm_pkg::CORR_ONE;
			scm_pkg::ST_DIV: begin
				if (div_ge) begin
					num_q <= div_num - den_ext;
					quo_q <= {quo_q[scm_pkg::CORR_FRAC-1:0], 1'b1};
				end else begin
					num_q <= div_num;
					quo_q <= {quo_q[scm_pkg::CORR_FRAC-1:0], 1'b0};
				end
			end
			scm_pkg::ST_SIGN:
				res_corr_q <= cross_q[scm_pkg::SUM_W-1] ? -$signed({1'b0, quo_q})
				                                        : $signed({1'b0, quo_q});
			default: ;
		endcase
	end

	// Output register: a new result loads only once the old one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == scm_pkg::ST_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == scm_pkg::ST_OUT && out_free) begin
			corr_q   <= res_corr_q;
			silent_q <= res_silent_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.correlation = corr_q;
	assign result.silent      = silent_q;

endmodule

[hdl/scm_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the stereo correlation meter and the bind that
// attaches them to the top level. Depends on stereo_correlation_meter and scm_if.
module scm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] correlation,
	input logic        silent
);

	// A result beat stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// Accepting a sample makes the block busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted while an item is in work");

	// The correlation never leaves plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(correlation) <= 16'sd16384 &&
		               $signed(correlation) >= -16'sd16384))
		else $error("correlation out of range");

	// A silent block reports zero correlation.
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && silent |-> correlation == 16'd0)
		else $error("silent result with nonzero correlation");

endmodule

bind stereo_correlation_meter scm_checker u_scm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.correlation (result.correlation),
	.silent      (result.silent)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for stereo_correlation_meter: directed table, a zero-decay
// check, then random blocks of samples checked against a bit-true predictor of the meter.
// Depends on scm_pkg, the scm_*_if interfaces and the stereo_correlation_meter RTL.
module testbench;

	localparam int S_BITS = 24;
	localparam logic [scm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [scm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam logic signed [S_BITS-1:0] S_MAX = 24'sh7fffff;
	localparam logic signed [S_BITS-1:0] S_MIN = 24'sh800000;
	localparam int WATCHDOG_LIMIT = 6000;
	// Room for the slowest item, a block end, plus margin.
	localparam int SETTLE_CYCLES = 160;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic signed [scm_pkg::CORR_W-1:0] corr;
		logic                              silent;
	} meter_result_t;

	typedef struct {
		logic signed [S_BITS-1:0] left;
		logic signed [S_BITS-1:0] right;
		logic                     last;
		logic                     typed;
		meter_result_t            known;
	} stim_row_t;

	logic clk;
	logic arst_n;

	scm_sample_if #(.SAMPLE_BITS(S_BITS)) sif();
	scm_result_if rif();
	scm_cfg_if    cif();

	stereo_correlation_meter #(.SAMPLE_BITS(S_BITS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sif),
		.result (rif),
		.cfg    (cif)
	);

	// Predictor copy of the registers and the three leaky sums.
	logic [scm_pkg::DECAY_W-1:0]   mdl_decay;
	logic [scm_pkg::MIN_DEN_W-1:0] mdl_min_den;
	logic signed [63:0]   mdl_cross;
	logic signed [63:0]   mdl_left_e;
	logic signed [63:0]   mdl_right_e;

	meter_result_t pending_results[$];
	int  mismatches;
	int  beats_in;
	bit  sample_taken;
	bit  cfg_taken;

	// Fields of the beat on the sample channel that carry a typed expectation.
	logic          drv_typed;
	meter_result_t drv_known;

	stim_row_t table_rows[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] w;
		w = {a[63], a} + {b[63], b};
		if (w > 65'sh0_7fff_ffff_ffff_ffff)
			return 64'sh7fff_ffff_ffff_ffff;
		if (w < -65'sh0_8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return w[63:0];
	endfunction

	// Arithmetic shift of the full product gives the floor that the meter uses.
	function automatic logic signed [63:0] leak(logic signed [63:0] s,
			logic [scm_pkg::DECAY_W-1:0] d);
		logic signed [88:0] m;
		logic signed [24:0] ds;
		ds = $signed({1'b0, d});
		m = s * ds;
		m = m >>> 24;
		return m[63:0];
	endfunction

	function automatic logic [63:0] energy_root(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		logic [127:0] t;
		logic [63:0] r;
		r = '0;
		p = {64'd0, a} * {64'd0, b};
		for (int bit_i = 62; bit_i >= 0; bit_i--) begin
			t = {64'd0, r | (64'd1 << bit_i)};
			if (t * t <= p)
				r = t[63:0];
		end
		return r;
	endfunction

	// Advances the sums by one sample pair; returns 1 and the reading on a block end.
	function automatic bit meter_step(logic signed [S_BITS-1:0] l,
			logic signed [S_BITS-1:0] r, logic last, output meter_result_t res);
		logic signed [63:0] lx, rx;
		logic [63:0] den, num;
		logic [127:0] q;
		logic [scm_pkg::CORR_W-1:0] qv;
		lx = l;
		rx = r;
		mdl_cross   = leak(sat_add64(mdl_cross, lx * rx), mdl_decay);
		mdl_left_e  = leak(sat_add64(mdl_left_e, lx * lx), mdl_decay);
		mdl_right_e = leak(sat_add64(mdl_right_e, rx * rx), mdl_decay);
		res.corr = '0;
		res.silent = 1'b0;
		if (!last)
			return 1'b0;
		den = energy_root(mdl_left_e, mdl_right_e);
		if (den <= {24'd0, mdl_min_den}) begin
			res.silent = 1'b1;
			return 1'b1;
		end
		num = mdl_cross[63] ? (64'd0 - mdl_cross) : mdl_cross;
		if (num >= den)
			q = scm_pkg::CORR_ONE;
		else
			q = ({64'd0, num} << scm_pkg::CORR_FRAC) / {64'd0, den};
		qv = q[scm_pkg::CORR_W-1:0];
		res.corr = mdl_cross[63] ? -qv : qv;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Sample channel: every accepted beat is fed to the predictor here, at the
	// same edge at which the block takes it.
	always @(posedge clk) begin
		meter_result_t res;
		if (sif.valid && sif.ready) begin
			if (meter_step(sif.left_sample, sif.right_sample, sif.block_end, res))
				pending_results.push_back(drv_typed ? drv_known : res);
			beats_in++;
			sample_taken = 1'b1;
		end
	end

	// Configuration channel: the predictor registers follow the accepted writes.
	always @(posedge clk) begin
		if (cif.valid && cif.ready) begin
			case (cif.index)
				scm_pkg::CFG_DECAY: begin
					mdl_decay = cif.data[scm_pkg::DECAY_W-1:0];
				end
				scm_pkg::CFG_MIN_DEN: begin
					mdl_min_den = cif.data[scm_pkg::MIN_DEN_W-1:0];
				end
				default: begin
				end
			endcase
			cfg_taken = 1'b1;
		end
	end

	// Result channel: each beat is checked against the oldest expectation.
	always @(posedge clk) begin
		meter_result_t want;
		if (rif.valid && rif.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, correlation", rif.correlation, 0);
			end else begin
				want = pending_results.pop_front();
				if (rif.correlation !== want.corr)
					report_mismatch("correlation", rif.correlation, want.corr);
				if (rif.silent !== want.silent)
					report_mismatch("silent", rif.silent, want.silent);
			end
		end
	end

	// The watchdog counts cycles in which no channel moves a beat.
	int quiet_cycles;
	always @(posedge clk) begin
		if ((sif.valid && sif.ready) || (rif.valid && rif.ready) ||
				(cif.valid && cif.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("stereo_correlation_meter test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Idle rates by stage of the run: the receiver idles more first, then the
	// sender, then neither. Both sides derive the stage from the beat count.
	function automatic int sender_idle_pct();
		if (beats_in < 450)
			return 35;
		if (beats_in < 900)
			return 51;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (beats_in < 450)
			return 51;
		if (beats_in < 900)
			return 35;
		return 0;
	endfunction

	// Receiver. Once, in the middle of the run, it holds ready low for a long
	// stretch so that the output register fills and the sample channel stalls.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		rif.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && beats_in >= 600) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rif.ready <= 1'b0;
				hold_left--;
			end else begin
				rif.ready <= ($urandom_range(99) >= receiver_idle_pct());
			end
		end
	end

	// Offers one sample beat from a falling edge and returns at the falling
	// edge after it was taken, with valid still high.
	task automatic send_pair(logic signed [S_BITS-1:0] l, logic signed [S_BITS-1:0] r,
			logic last, logic typed, meter_result_t known);
		while ($urandom_range(99) < sender_idle_pct()) begin
			sif.valid <= 1'b0;
			@(negedge clk);
		end
		sif.left_sample  <= l;
		sif.right_sample <= r;
		sif.block_end    <= last;
		drv_typed        <= typed;
		drv_known        <= known;
		sif.valid        <= 1'b1;
		do @(negedge clk); while (!sample_taken);
		sample_taken = 1'b0;
	endtask

	// Offers one register write and returns one falling edge after valid drops.
	task automatic write_reg(logic [scm_pkg::CFG_IDX_W-1:0] idx,
			logic [scm_pkg::CFG_DATA_W-1:0] value);
		cif.index <= idx;
		cif.data  <= value;
		cif.valid <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_taken = 1'b0;
		cif.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Lets the block drain: all results in, then time for a trailing sample
	// that causes no result.
	task automatic drain();
		sif.valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic add_row(logic signed [S_BITS-1:0] l, logic signed [S_BITS-1:0] r,
			logic last, logic typed, logic signed [scm_pkg::CORR_W-1:0] corr,
			logic silent);
		stim_row_t row;
		row.left = l;
		row.right = r;
		row.last = last;
		row.typed = typed;
		row.known.corr = corr;
		row.known.silent = silent;
		table_rows.push_back(row);
	endtask

	function automatic logic signed [S_BITS-1:0] rand_sample(int style);
		case (style)
			0: return S_BITS'(int'($urandom_range(15)) - 8);
			1: return ($urandom_range(1) != 0) ? S_MAX : S_MIN;
			default: return S_BITS'($urandom());
		endcase
	endfunction

	// One block of random content; most blocks are well formed and end with a
	// block end, a few are noise with the end flag set at random.
	task automatic send_random_block(inout int sent);
		int len, style;
		logic signed [S_BITS-1:0] l, r;
		logic last;
		meter_result_t none;
		none.corr = '0;
		none.silent = 1'b0;
		len = $urandom_range(10, 1);
		style = $urandom_range(9);
		for (int k = 0; k < len; k++) begin
			case (style)
				4, 5: l = rand_sample(2);
				6: l = rand_sample(0);
				7: l = rand_sample(1);
				default: l = rand_sample($urandom_range(9) == 0 ? 1 : 2);
			endcase
			case (style)
				4: r = l;
				5: r = ~l;
				6: r = rand_sample(0);
				7: r = rand_sample(1);
				8: r = '0;
				default: r = rand_sample(2);
			endcase
			last = (style == 9) ? 1'($urandom_range(1)) : (k == len - 1);
			send_pair(l, r, last, 1'b0, none);
			sent++;
		end
	endtask

	initial begin
		int sent;
		logic [scm_pkg::CFG_DATA_W-1:0] rnd;
		mismatches = 0;
		beats_in = 0;
		sample_taken = 1'b0;
		cfg_taken = 1'b0;
		quiet_cycles = 0;
		mdl_decay = scm_pkg::DECAY_RESET;
		mdl_min_den = scm_pkg::MIN_DEN_RESET;
		mdl_cross = '0;
		mdl_left_e = '0;
		mdl_right_e = '0;
		drv_typed = 1'b0;
		drv_known.corr = '0;
		drv_known.silent = 1'b0;
		sif.valid = 1'b0;
		sif.left_sample = '0;
		sif.right_sample = '0;
		sif.block_end = 1'b0;
		cif.valid = 1'b0;
		cif.index = scm_pkg::CFG_DECAY;
		cif.data = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table at the reset register values. A block end straight
		// after reset has all-zero sums and must read silent. Equal full-scale
		// samples keep the three sums equal, so the ratio clamps to +1.
		add_row('0, '0, 1'b1, 1'b1, 16'sd0, 1'b1);
		add_row(S_MAX, S_MAX, 1'b1, 1'b1, 16'sd16384, 1'b0);
		add_row(S_MIN, S_MIN, 1'b1, 1'b1, 16'sd16384, 1'b0);
		add_row(S_MIN, S_MAX, 1'b0, 1'b0, 0, 0);
		add_row(S_MAX, S_MIN, 1'b1, 1'b0, 0, 0);
		add_row(S_MIN, S_MAX, 1'b1, 1'b0, 0, 0);
		add_row(24'sh555555, 24'shaaaaaa, 1'b1, 1'b0, 0, 0);
		add_row(24'shaaaaaa, 24'sh555555, 1'b1, 1'b0, 0, 0);
		add_row(S_MAX, '0, 1'b0, 1'b0, 0, 0);
		add_row('0, S_MAX, 1'b1, 1'b0, 0, 0);
		add_row(24'sd1, -24'sd1, 1'b1, 1'b0, 0, 0);
		add_row(-24'sd1, '0, 1'b1, 1'b0, 0, 0);
		add_row(S_MIN, -24'sd1, 1'b0, 1'b0, 0, 0);
		add_row(24'sh123456, 24'sh654321, 1'b1, 1'b0, 0, 0);
		foreach (table_rows[i])
			send_pair(table_rows[i].left, table_rows[i].right, table_rows[i].last,
				table_rows[i].typed, table_rows[i].known);
		drain();

		// Zero decay empties every sum each sample, so every block reads silent
		// through a zero denominator even with no threshold at all.
		write_reg(scm_pkg::CFG_DECAY, '0);
		write_reg(scm_pkg::CFG_MIN_DEN, '0);
		send_pair(S_MAX, S_MAX, 1'b1, 1'b1, '{corr: 16'sd0, silent: 1'b1});
		send_pair(S_MIN, S_MAX, 1'b1, 1'b1, '{corr: 16'sd0, silent: 1'b1});
		drain();

		sent = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(scm_pkg::CFG_DECAY, {16'hffff, scm_pkg::DECAY_RESET});
					write_reg(scm_pkg::CFG_MIN_DEN, {24'd0, scm_pkg::MIN_DEN_RESET});
				end
				1: begin
					write_reg(scm_pkg::CFG_DECAY, {scm_pkg::CFG_DATA_W{1'b1}});
					write_reg(scm_pkg::CFG_MIN_DEN, '0);
				end
				2: begin
					write_reg(scm_pkg::CFG_DECAY, 40'd1);
					write_reg(scm_pkg::CFG_MIN_DEN, {scm_pkg::CFG_DATA_W{1'b1}});
				end
				3: begin
					rnd = scm_pkg::CFG_DATA_W'({$urandom(), $urandom()});
					write_reg(scm_pkg::CFG_DECAY, rnd);
					write_reg(scm_pkg::CFG_MIN_DEN,
						scm_pkg::CFG_DATA_W'({$urandom_range(255), $urandom()}));
				end
				4: begin
					write_reg(scm_pkg::CFG_DECAY, 40'hffffff - $urandom_range(4095));
					write_reg(scm_pkg::CFG_MIN_DEN,
						scm_pkg::CFG_DATA_W'({$urandom(), $urandom()}));
				end
				default: begin
					// Writes to indexes past the two registers change nothing.
					write_reg(CFG_SPARE_A, scm_pkg::CFG_DATA_W'({$urandom(), $urandom()}));
					write_reg(CFG_SPARE_B, scm_pkg::CFG_DATA_W'({$urandom(), $urandom()}));
					write_reg(scm_pkg::CFG_DECAY, 40'hff0000 | $urandom_range(65535));
				end
			endcase
			while (sent < (phase + 1) * 225)
				send_random_block(sent);
			drain();
		end

		if (mismatches == 0)
			$display("stereo_correlation_meter test passed");
		else
			$display("stereo_correlation_meter test failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/scm_pkg.sv
hdl/scm_if.sv
hdl/stereo_correlation_meter.sv
hdl/scm_checker.sv
tb/testbench.sv
